// ===== design/fsd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Floyd-Steinberg dither core.
package fsd_pkg;

  localparam int PIXEL_W        = 8;
  localparam int ERR_W          = 8;
  localparam int SUM_W          = 10;
  localparam int PROD_W         = 12;
  localparam int IMG_W_W        = 12;
  localparam int IMG_H_W        = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int THRESHOLD      = 128;
  localparam int WHITE_LEVEL    = 255;

  localparam logic [2:0] WEIGHT_UP_LEFT  = 3'd1;
  localparam logic [2:0] WEIGHT_UP       = 3'd5;
  localparam logic [2:0] WEIGHT_UP_RIGHT = 3'd3;
  localparam logic [2:0] WEIGHT_LEFT     = 3'd7;

  typedef logic [PIXEL_W-1:0]       pixel_t;
  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic use_up_left;
    logic use_up;
    logic use_up_right;
    logic use_left;
  } share_sel_t;

  // Weighted share of an error, divided by 16 with truncation toward zero
  function automatic sum_t share(input err_t e, input logic [2:0] wgt);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] adj;
    p   = e * $signed({1'b0, wgt});
    adj = p + (p[PROD_W-1] ? PROD_W'(15) : PROD_W'(0));
    return SUM_W'(adj >>> 4);
  endfunction

  function automatic pixel_t clamp_level(input sum_t v);
    pixel_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > SUM_W'(WHITE_LEVEL)) begin
      r = PIXEL_W'(WHITE_LEVEL);
    end else begin
      r = v[PIXEL_W-1:0];
    end
    return r;
  endfunction

  function automatic pixel_t add_share(input pixel_t v, input err_t e, input logic [2:0] wgt);
    sum_t s;
    s = $signed({2'b00, v}) + share(e, wgt);
    return clamp_level(s);
  endfunction

endpackage

// ===== design/fsd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/fsd_kernel.sv =====
// Error correction, threshold and new error for one pixel.
module fsd_kernel (
  input  fsd_pkg::pixel_t     pixel,
  input  fsd_pkg::err_t       upper_left,
  input  fsd_pkg::err_t       up,
  input  fsd_pkg::err_t       upper_right,
  input  fsd_pkg::err_t       left,
  input  fsd_pkg::share_sel_t sel,
  output logic                dither_bit,
  output fsd_pkg::err_t       err
);
  import fsd_pkg::*;

  pixel_t v1, v2, v3, v4;
  sum_t   diff;

  always_comb begin
    v1 = sel.use_up_left  ? add_share(pixel, upper_left, WEIGHT_UP_LEFT) : pixel;
    v2 = sel.use_up       ? add_share(v1, up, WEIGHT_UP)                 : v1;
    v3 = sel.use_up_right ? add_share(v2, upper_right, WEIGHT_UP_RIGHT)  : v2;
    v4 = sel.use_left     ? add_share(v3, left, WEIGHT_LEFT)             : v3;
    dither_bit = (v4 >= PIXEL_W'(THRESHOLD));
    diff = $signed({2'b00, v4}) - (dither_bit ? SUM_W'(WHITE_LEVEL) : SUM_W'(0));
    err  = ERR_W'(diff);
  end

endmodule

// ===== design/floyd_steinberg_dither_core.sv =====
// Top level of the Floyd-Steinberg error-diffusion dither core.
// Takes one 8-bit grey pixel per clock in raster order while out_stall does not hold the
// output, and returns one dithered bit per pixel, with frame_last marking the final pixel
// of each frame. The pixel passes an input register, then a result register. The previous
// row's errors sit in a MAX_WIDTH-entry line buffer with one write and one registered
// read per cycle; the read runs one column ahead of the pixel being processed, with a
// write-to-read bypass. The line buffer needs no clearing after reset: row 0 of every
// frame ignores it. image_width and image_height may be written only while the core is
// idle.
module floyd_steinberg_dither_core #(
  parameter int MAX_WIDTH = fsd_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  fsd_pkg::cfg_index_t           cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fsd_pkg::PIXEL_W-1:0]   pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          pixel_bit,
  output logic                          frame_last
);
  import fsd_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int EW = (IMG_W_W > XW + 1) ? IMG_W_W : XW + 1;

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;

  logic         s1_valid;
  pixel_t       s1_pixel;

  logic [XW-1:0]      column_count, column_count_next;
  logic [IMG_H_W-1:0] row_count, row_count_next;
  err_t               left_error;
  err_t               upper_left_error;
  err_t               up_error;
  err_t               col0_error;
  logic               byp_valid;
  err_t               byp_error;

  logic         fire;
  logic [EW-1:0] w_eff;
  logic [EW-1:0] x_plus1;
  logic [IMG_H_W-1:0] h_eff;
  logic         last_col, last_row;
  logic [EW-1:0] rd_next;
  logic [XW-1:0] rd_addr;
  logic [ERR_W-1:0] ram_rdata;

  err_t         up_cur, ur_cur, err;
  logic         dither_bit;
  share_sel_t   sel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_W'(WIDTH_RESET);
      image_height <= IMG_H_W'(HEIGHT_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
      endcase
    end
  end

  // Handshake
  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pixel <= pixel_in;
    end
    if (fire) begin
      pixel_bit  <= dither_bit;
      frame_last <= last_col && last_row;
    end
  end

  // Frame position
  always_comb begin
    if (image_width == '0) begin
      w_eff = EW'(1);
    end else if (EW'(image_width) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width);
    end
    h_eff    = (image_height == '0) ? IMG_H_W'(1) : image_height;
    x_plus1  = EW'(column_count) + EW'(1);
    last_col = (x_plus1 >= w_eff);
    last_row = ({1'b0, row_count} + (IMG_H_W + 1)'(1)) >= {1'b0, h_eff};
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (fire) begin
      if (last_col) begin
        column_count_next = '0;
        row_count_next    = last_row ? '0 : row_count + IMG_H_W'(1);
      end else begin
        column_count_next = x_plus1[XW-1:0];
      end
    end
    rd_next = EW'(column_count_next) + EW'(1);
    rd_addr = (rd_next >= EW'(MAX_WIDTH)) ? '0 : rd_next[XW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_count        <= '0;
      left_error       <= '0;
      upper_left_error <= '0;
      up_error         <= '0;
      col0_error       <= '0;
      byp_valid        <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      byp_valid    <= fire && (rd_addr == column_count);
      if (fire) begin
        left_error       <= err;
        upper_left_error <= up_cur;
        up_error         <= ur_cur;
        if (column_count == '0) begin
          col0_error <= err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byp_error <= err;
    end
  end

  fsd_ram #(
    .WIDTH(ERR_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk    (clk),
    .wr_en  (fire),
    .wr_addr(column_count),
    .wr_data(err),
    .rd_addr(rd_addr),
    .rd_data(ram_rdata)
  );

  // Neighbour errors for the current pixel
  always_comb begin
    up_cur           = (column_count == '0) ? col0_error : up_error;
    ur_cur           = byp_valid ? byp_error : $signed(ram_rdata);
    sel.use_up_left  = (row_count != '0) && (column_count != '0);
    sel.use_up       = (row_count != '0);
    sel.use_up_right = (row_count != '0) && (x_plus1 < w_eff);
    sel.use_left     = (column_count != '0);
  end

  fsd_kernel u_kernel (
    .pixel      (s1_pixel),
    .upper_left (upper_left_error),
    .up         (up_cur),
    .upper_right(ur_cur),
    .left       (left_error),
    .sel        (sel),
    .dither_bit (dither_bit),
    .err        (err)
  );

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline can advance");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    fire && last_col && last_row |=> column_count == '0 && row_count == '0)
    else $error("position did not wrap at frame end");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    fire && !last_col |=> column_count == XW'($past(column_count) + 1'b1))
    else $error("column did not advance by one");

  a_bypass_source: assert property (@(posedge clk) disable iff (rst)
    byp_valid |-> $past(fire))
    else $error("bypass set without a line buffer write");

endmodule

// ===== sim/tb_floyd_steinberg_dither_core.sv =====
// Self-checking testbench for the Floyd-Steinberg dither core: directed table, then random frames.
module tb_floyd_steinberg_dither_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fsd_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1200;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic pixel_bit;
    logic frame_last;
  } dot_t;

  typedef struct packed {
    logic typed;
    dot_t dot;
  } known_t;

  typedef enum logic [0:0] {
    PLAN_GREY = 1'b0,
    PLAN_REG  = 1'b1
  } plan_kind_t;

  typedef enum int {
    GREY_ANY   = 0,
    GREY_EDGES = 1,
    GREY_FLAT  = 2
  } grey_mode_t;

  typedef struct packed {
    plan_kind_t             kind;
    cfg_index_t             idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [PIXEL_W-1:0]     grey;
    logic                   typed;
    logic                   want_bit;
    logic                   want_last;
  } plan_row_t;

  localparam int PLAN_N = 27;

  plan_row_t plan [PLAN_N] = '{
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd0,   1'b1, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd255, 1'b1, 1'b1, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd128, 1'b1, 1'b1, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd127, 1'b0, 1'b0, 1'b0},
    '{PLAN_REG,  REG_IMAGE_WIDTH,  16'h0000, 8'd0,   1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd200, 1'b0, 1'b0, 1'b0},
    '{PLAN_REG,  REG_IMAGE_HEIGHT, 16'h0000, 8'd0,   1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd10,  1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd0,   1'b1, 1'b0, 1'b1},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd255, 1'b1, 1'b1, 1'b1},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd128, 1'b1, 1'b1, 1'b1},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd127, 1'b1, 1'b0, 1'b1},
    '{PLAN_REG,  REG_IMAGE_WIDTH,  16'hF003, 8'd0,   1'b0, 1'b0, 1'b0},
    '{PLAN_REG,  REG_IMAGE_HEIGHT, 16'hFFFF, 8'd0,   1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd255, 1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd0,   1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd128, 1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd127, 1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd255, 1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd255, 1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd0,   1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd0,   1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd64,  1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd200, 1'b0, 1'b0, 1'b0},
    '{PLAN_REG,  REG_IMAGE_HEIGHT, 16'h0002, 8'd0,   1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd90,  1'b0, 1'b0, 1'b0},
    '{PLAN_GREY, REG_IMAGE_WIDTH,  16'h0000, 8'd170, 1'b0, 1'b0, 1'b0}
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  cfg_index_t             cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [PIXEL_W-1:0]     pixel_in = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   pixel_bit;
  logic                   frame_last;

  logic [IMG_W_W-1:0] reg_width = IMG_W_W'(WIDTH_RESET);
  logic [IMG_H_W-1:0] reg_height = IMG_H_W'(HEIGHT_RESET);
  err_t               err_line [MAX_W];
  int                 col_pos = 0;
  int                 row_pos = 0;
  int                 err_left = 0;
  int                 err_up_left = 0;

  dot_t   expected_dots [$];
  known_t typed_dots [$];
  int     errors = 0;
  bit     steady = 1'b0;

  floyd_steinberg_dither_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_bit  (pixel_bit),
    .frame_last (frame_last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int eff_width();
    if (reg_width == 0) return 1;
    if (int'(reg_width) > MAX_W) return MAX_W;
    return int'(reg_width);
  endfunction

  function automatic int eff_height();
    return (reg_height == 0) ? 1 : int'(reg_height);
  endfunction

  function automatic int clip_grey(input int v);
    if (v < 0) return 0;
    if (v > WHITE_LEVEL) return WHITE_LEVEL;
    return v;
  endfunction

  function automatic dot_t dither_pixel(input logic [PIXEL_W-1:0] grey);
    int   w;
    int   h;
    int   v;
    int   up;
    int   e;
    dot_t d;
    w  = eff_width();
    h  = eff_height();
    v  = int'(grey);
    up = int'(err_line[col_pos]);
    if (row_pos > 0) begin
      if (col_pos > 0) v = clip_grey(v + (err_up_left * 1) / 16);
      v = clip_grey(v + (up * 5) / 16);
      if (col_pos + 1 < w) v = clip_grey(v + (int'(err_line[col_pos + 1]) * 3) / 16);
    end
    if (col_pos > 0) v = clip_grey(v + (err_left * 7) / 16);
    d.pixel_bit = (v >= THRESHOLD);
    e = d.pixel_bit ? v - WHITE_LEVEL : v;
    err_up_left = up;
    err_line[col_pos] = err_t'(e);
    err_left = e;
    d.frame_last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return d;
  endfunction

  function automatic int pixels_to_frame_end();
    int w;
    int h;
    int row_rem;
    w = eff_width();
    h = eff_height();
    row_rem = (col_pos >= w) ? 1 : w - col_pos;
    if (row_pos + 1 >= h) return row_rem;
    return row_rem + (h - row_pos - 1) * w;
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_grey(input grey_mode_t mode, input int level);
    int g;
    case (mode)
      GREY_ANY: begin
        g = $urandom_range(0, 255);
      end
      GREY_EDGES: begin
        case ($urandom_range(0, 3))
          0: g = 0;
          1: g = THRESHOLD - 1;
          2: g = THRESHOLD;
          default: g = WHITE_LEVEL;
        endcase
      end
      default: begin
        g = level + int'($urandom_range(0, 6)) - 3;
      end
    endcase
    return PIXEL_W'(clip_grey(g));
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    known_t tag;
    dot_t   want;
    dot_t   got;
    if (rst) begin
      reg_width   = IMG_W_W'(WIDTH_RESET);
      reg_height  = IMG_H_W'(HEIGHT_RESET);
      col_pos     = 0;
      row_pos     = 0;
      err_left    = 0;
      err_up_left = 0;
      expected_dots.delete();
      typed_dots.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  reg_width = cfg_data[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT: reg_height = cfg_data[IMG_H_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = dither_pixel(pixel_in);
        if (typed_dots.size() != 0) begin
          tag = typed_dots.pop_front();
          if (tag.typed) want = tag.dot;
        end
        expected_dots.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{pixel_bit, frame_last};
        if (expected_dots.size() == 0) begin
          report($sformatf("unexpected item: bit %0b last %0b", got.pixel_bit, got.frame_last));
        end else begin
          want = expected_dots.pop_front();
          if (got.pixel_bit !== want.pixel_bit || got.frame_last !== want.frame_last) begin
            report($sformatf("mismatch: expected bit %0b last %0b, got bit %0b last %0b",
                             want.pixel_bit, want.frame_last, got.pixel_bit, got.frame_last));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 31);
    end
  end

  task automatic send_grey(input logic [PIXEL_W-1:0] g, input logic typed, input dot_t want);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_dots.push_back(known_t'{typed, want});
    in_valid <= 1'b1;
    pixel_in <= g;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_run(input int n, input grey_mode_t mode, input int level);
    int k;
    for (k = 0; k < n; k++) send_grey(pick_grey(mode, level), 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_dots.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic finish_frame(input grey_mode_t mode, input int level);
    wait_idle();
    if (col_pos != 0 || row_pos != 0) send_run(pixels_to_frame_end(), mode, level);
  endtask

  initial begin
    int         i;
    int         r;
    int         w;
    int         h;
    int         total;
    int         cut;
    int         level;
    int         random_count;
    grey_mode_t mode;
    plan_row_t  row;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_N; i++) begin
      row = plan[i];
      if (row.kind == PLAN_REG) begin
        write_reg(row.idx, row.data);
      end else begin
        send_grey(row.grey, row.typed, '{row.want_bit, row.want_last});
      end
    end
    finish_frame(GREY_ANY, 0);

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      steady = (random_count >= 500 && random_count < 700);
      r = $urandom_range(0, 99);
      if (r < 5) w = 0;
      else if (r < 75) w = $urandom_range(1, 8);
      else if (r < 95) w = $urandom_range(9, 40);
      else w = $urandom_range(41, 200);
      r = $urandom_range(0, 99);
      if (r < 10) h = 0;
      else if (r < 85) h = $urandom_range(1, 5);
      else h = $urandom_range(6, 12);
      if (w > 40) h = $urandom_range(1, 2);
      if ($urandom_range(0, 1)) begin
        write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
      end else begin
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
      end
      mode  = grey_mode_t'($urandom_range(0, 2));
      level = $urandom_range(0, 255);
      wait_idle();
      total = pixels_to_frame_end();
      if (total > 2 && $urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, total - 1);
        send_run(cut, mode, level);
        if ($urandom_range(0, 1)) begin
          write_reg(REG_IMAGE_WIDTH,
                    {4'($urandom_range(0, 15)), 12'($urandom_range(0, eff_width()))});
        end else begin
          write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(0, eff_height())));
        end
        finish_frame(mode, level);
      end else begin
        send_run(total, mode, level);
      end
      random_count += total;
    end
    steady = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_dots.size() != 0) report("items still expected at end of run");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
